[hdl/midi_chord_step_sequencer_top_macros.svh]
// ----------------------------------------------------------------------------
// midi chord step sequencer assertion macros
// shared property forms for the sequencer checks
// ----------------------------------------------------------------------------
`ifndef MIDI_CHORD_STEP_SEQUENCER_TOP_MACROS_SVH
`define MIDI_CHORD_STEP_SEQUENCER_TOP_MACROS_SVH

// condition implies consequence in the same cycle
`define MCSS_ASSERT_SAME(lbl, clk, rst_n, cond, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (cons)) else $error(msg);

// condition implies consequence in the next cycle
`define MCSS_ASSERT_NEXT(lbl, clk, rst_n, cond, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) else $error(msg);

`endif

[hdl/mcss_pkg.sv]
// ----------------------------------------------------------------------------
// mcss_pkg
// types, codes and helpers of the chord step sequencer
// ----------------------------------------------------------------------------
package mcss_pkg;

  localparam logic [3:0] ACT_MIDI_BYTE   = 4'd0;
  localparam logic [3:0] ACT_MS_TICK     = 4'd1;
  localparam logic [3:0] ACT_TOGGLE_PLAY = 4'd2;
  localparam logic [3:0] ACT_TOGGLE_STEP = 4'd3;
  localparam logic [3:0] ACT_BEGIN_EDIT  = 4'd4;
  localparam logic [3:0] ACT_END_EDIT    = 4'd5;
  localparam logic [3:0] ACT_TOGGLE_KEY  = 4'd6;
  localparam logic [3:0] ACT_SET_NOTE    = 4'd7;
  localparam logic [3:0] ACT_CLEAR       = 4'd8;

  localparam logic [7:0] MB_PULSE = 8'hF8;
  localparam logic [7:0] MB_START = 8'hFA;
  localparam logic [7:0] MB_CONT  = 8'hFB;
  localparam logic [7:0] MB_STOP  = 8'hFC;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 9;
  localparam logic [CFG_IDX_W-1:0] CFG_TEMPO   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CHANNEL = 2'd1;

  localparam logic [8:0]  TEMPO_RESET  = 9'd120;
  localparam logic [7:0]  ROOT_DEFAULT = 8'd60;
  localparam logic [6:0]  NOTE_DEFAULT = 7'd60;
  localparam logic [6:0]  VEL_ON       = 7'd127;
  localparam logic [7:0]  PITCH_MAX    = 8'd127;
  localparam logic [25:0] TICK_LIMIT   = 26'd15000;
  localparam int          NOTES        = 12;

  typedef struct packed {
    logic [3:0]  action;
    logic [7:0]  clock_byte;
    logic [3:0]  step_index;
    logic [11:0] chord_mask;
    logic [3:0]  key_index;
    logic [6:0]  note_value;
  } in_item_t;

  typedef struct packed {
    logic        note_on;
    logic [6:0]  pitch;
    logic [6:0]  velocity;
    logic [3:0]  channel;
    logic        last;
    logic [3:0]  position;
    logic        running;
  } out_event_t;

  typedef struct packed {
    logic        load;
    logic [11:0] off_mask;
    logic [7:0]  off_base;
    logic [11:0] on_mask;
    logic [7:0]  on_base;
  } scan_load_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_READ_A, ST_EXEC, ST_READ_B, ST_ON, ST_EMIT
  } seq_state_t;

  // note rounded down to a multiple of twelve, reciprocal multiply
  function automatic logic [7:0] octave_base(input logic [7:0] note);
    logic [15:0] prod;
    logic [7:0]  q;
    prod = {8'b0, note} * 16'd171;
    q    = {3'b0, prod[15:11]};
    return 8'(q * 8'd12);
  endfunction

  function automatic logic [3:0] pitch_class(input logic [7:0] note);
    logic [7:0] r;
    r = note - octave_base(note);
    return r[3:0];
  endfunction

endpackage

[hdl/mcss_if.sv]
// ----------------------------------------------------------------------------
// mcss channel interfaces
// valid/ready channels for items, events and register writes
// ----------------------------------------------------------------------------
interface mcss_item_if import mcss_pkg::*; ();
  logic     valid;
  logic     ready;
  in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface mcss_event_if import mcss_pkg::*; ();
  logic       valid;
  logic       ready;
  out_event_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface mcss_cfg_if import mcss_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

[hdl/midi_chord_step_sequencer_top.sv]
// after an item transfer the ON state loads the scanner; the scanner then gives one event
// per cycle while out_ch.ready is high; a new item is taken only when the scan is done
// ready is high only in idle; each item walks read, execute, read, load, emit
// reset: synchronous active-low rst_n clears playback, position, counters,
// edit state and step valid bits at once; no clearing pass
// ----------------------------------------------------------------------------
// midi_chord_step_sequencer_top
// chord step sequencer: step store, sequencer and event scanner
// ----------------------------------------------------------------------------
module midi_chord_step_sequencer_top import mcss_pkg::*; #(
  parameter int NUM_STEPS   = 16,
  parameter int PULSES_STEP = 6
) (
  input  logic           clk,
  input  logic           rst_n,
  mcss_item_if.sink      in_ch,
  mcss_event_if.source   out_ch,
  mcss_cfg_if.sink       cfg_ch
);
  localparam int PW  = (NUM_STEPS > 1) ? $clog2(NUM_STEPS) : 1;
  localparam int PCW = $clog2(PULSES_STEP + 1);

  seq_state_t state_r, state_nxt;
  in_item_t   it_r;

  logic [8:0]  tempo_r;
  logic [3:0]  chan_r;
  logic        play_r, play_nxt, ext_r, ext_nxt;
  logic [PW-1:0] pos_r, pos_nxt;
  logic [PCW-1:0] pulse_r, pulse_nxt;
  logic [15:0] ms_r, ms_nxt;
  logic [6:0]  rnote_r, rnote_nxt;
  logic        rvalid_r, rvalid_nxt;
  logic [11:0] rchord_r, rchord_nxt;
  logic        editv_r, editv_nxt;
  logic [PW-1:0] editp_r, editp_nxt;
  logic [11:0] sound_r, sound_nxt;
  logic [NUM_STEPS-1:0] on_r, on_nxt, val_r, val_nxt;
  logic        off_do_r, off_do_nxt, on_do_r, on_do_nxt;
  logic [11:0] off_mask_r, off_mask_nxt;
  logic [7:0]  off_base_r, off_base_nxt;
  logic [25:0] prod_r;

  logic          we;
  logic [19:0]   wdata, rdata;
  logic [PW-1:0] addr_a, raddr;
  logic [PW+3:0] s_ext, pos_ext;
  logic [PW-1:0] s_idx;
  logic          s_ok, scan_busy;
  logic [15:0]   elapsed;
  logic [8:0]    bpm;
  logic [PCW-1:0] pulse_inc;
  logic [PW-1:0] pos_inc;
  logic [11:0]   d_chord, n_chord, e_chord;
  logic [7:0]    d_root, n_root, e_root, src;
  scan_load_t    ld;

  assign s_ext   = {{PW{1'b0}}, it_r.step_index};
  assign s_idx   = s_ext[PW-1:0];
  assign s_ok    = 32'(it_r.step_index) < NUM_STEPS;
  assign pos_ext = {4'b0, pos_r};
  assign elapsed = (ms_r != 16'hFFFF) ? ms_r + 16'd1 : 16'hFFFF;
  assign bpm     = (tempo_r != 9'd0) ? tempo_r : 9'd1;
  assign pulse_inc = pulse_r + PCW'(1);
  assign pos_inc = (pos_r == PW'(NUM_STEPS - 1)) ? '0 : pos_r + PW'(1);
  assign src     = rvalid_r ? {1'b0, rnote_r} : ROOT_DEFAULT;

  always_comb begin
    unique case (it_r.action)
      ACT_TOGGLE_STEP: addr_a = s_idx;
      ACT_TOGGLE_KEY:  addr_a = editp_r;
      default:         addr_a = pos_r;
    endcase
  end

  assign raddr = (state_r == ST_READ_B) ? pos_r : addr_a;

  mcss_ram #(.WIDTH(20), .DEPTH(NUM_STEPS)) u_ram (
    .clk(clk), .we(we), .waddr(addr_a), .wdata(wdata), .raddr(raddr), .rdata(rdata)
  );

  assign d_chord = val_r[addr_a] ? rdata[19:8] : 12'd0;
  assign d_root  = val_r[addr_a] ? rdata[7:0] : ROOT_DEFAULT;
  assign e_chord = val_r[pos_r] ? rdata[19:8] : 12'd0;
  assign e_root  = val_r[pos_r] ? rdata[7:0] : ROOT_DEFAULT;

  function automatic logic [7:0] root_from(input logic [11:0] c, input logic [7:0] s);
    logic [7:0] r;
    r = s;
    for (int i = NOTES - 1; i >= 0; i--) begin
      if (c[i]) begin
        r = octave_base(s) + 8'(i);
      end
    end
    return r;
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    play_nxt = play_r; ext_nxt = ext_r; pos_nxt = pos_r; pulse_nxt = pulse_r;
    ms_nxt = ms_r; rnote_nxt = rnote_r; rvalid_nxt = rvalid_r; rchord_nxt = rchord_r;
    editv_nxt = editv_r; editp_nxt = editp_r; sound_nxt = sound_r;
    on_nxt = on_r; val_nxt = val_r;
    off_do_nxt = off_do_r; on_do_nxt = on_do_r;
    off_mask_nxt = off_mask_r; off_base_nxt = off_base_r;
    we = 1'b0; n_chord = d_chord; n_root = d_root;
    ld = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_ch.valid) begin
          state_nxt = ST_READ_A;
        end
      end
      ST_READ_A: begin
        state_nxt = ST_EXEC;
      end
      ST_EXEC: begin
        state_nxt = ST_READ_B;
        off_do_nxt = 1'b0;
        on_do_nxt = 1'b0;
        off_base_nxt = octave_base(d_root);
        unique case (it_r.action)
          ACT_MIDI_BYTE: begin
            priority if (it_r.clock_byte == MB_PULSE) begin
              pulse_nxt = pulse_inc;
              if (pulse_inc >= PCW'(PULSES_STEP)) begin
                pulse_nxt = '0;
                if (play_r) begin
                  off_do_nxt = 1'b1; on_do_nxt = 1'b1;
                  pos_nxt = pos_inc; ms_nxt = '0;
                end
              end
            end else if (it_r.clock_byte == MB_START) begin
              ext_nxt = 1'b1; play_nxt = 1'b1; pos_nxt = '0; pulse_nxt = '0;
              ms_nxt = '0; off_do_nxt = 1'b1; on_do_nxt = 1'b1;
            end else if (it_r.clock_byte == MB_CONT) begin
              ext_nxt = 1'b1; play_nxt = 1'b1;
            end else if (it_r.clock_byte == MB_STOP) begin
              ext_nxt = 1'b0; play_nxt = 1'b0; pulse_nxt = '0; off_do_nxt = 1'b1;
            end else begin
            end
          end
          ACT_MS_TICK: begin
            if (!ext_r && play_r && (prod_r > TICK_LIMIT)) begin
              off_do_nxt = 1'b1; on_do_nxt = 1'b1; pos_nxt = pos_inc; ms_nxt = '0;
            end else begin
              ms_nxt = elapsed;
            end
          end
          ACT_TOGGLE_PLAY: begin
            off_do_nxt = 1'b1;
            if (play_r) begin
              play_nxt = 1'b0;
            end else begin
              play_nxt = 1'b1; pos_nxt = '0; pulse_nxt = '0; ms_nxt = '0;
              on_do_nxt = 1'b1;
            end
          end
          ACT_TOGGLE_STEP: begin
            if (s_ok) begin
              if (!on_r[s_idx]) begin
                on_nxt[s_idx] = 1'b1;
                if (d_chord != 12'd0) begin
                end else if (it_r.chord_mask != 12'd0) begin
                  n_chord = it_r.chord_mask;
                  rchord_nxt = it_r.chord_mask;
                  n_root = root_from(it_r.chord_mask, src);
                end else if (rchord_r != 12'd0) begin
                  n_chord = rchord_r;
                  n_root = root_from(rchord_r, src);
                end else begin
                  n_root = src;
                  n_chord = 12'd1 << pitch_class(src);
                end
                we = 1'b1;
                val_nxt[s_idx] = 1'b1;
                if (play_r && pos_r == s_idx) begin
                  off_do_nxt = 1'b1; on_do_nxt = 1'b1;
                  off_base_nxt = octave_base(n_root);
                end
              end else begin
                on_nxt[s_idx] = 1'b0;
                if (play_r && pos_r == s_idx) begin
                  off_do_nxt = 1'b1;
                end
              end
            end
          end
          ACT_BEGIN_EDIT: begin
            if (s_ok) begin
              editv_nxt = 1'b1; editp_nxt = s_idx;
            end
          end
          ACT_END_EDIT: begin
            editv_nxt = 1'b0;
          end
          ACT_TOGGLE_KEY: begin
            if (editv_r && it_r.key_index < 4'd12 && on_r[editp_r]) begin
              n_chord = d_chord ^ (12'd1 << it_r.key_index);
              if (n_chord[it_r.key_index]) begin
                n_root = octave_base(d_root) + 8'(it_r.key_index);
              end
              we = 1'b1;
              val_nxt[editp_r] = 1'b1;
              if (n_chord == 12'd0) begin
                on_nxt[editp_r] = 1'b0;
              end else begin
                rchord_nxt = n_chord;
              end
            end
          end
          ACT_SET_NOTE: begin
            rnote_nxt = it_r.note_value; rvalid_nxt = 1'b1;
          end
          ACT_CLEAR: begin
            off_do_nxt = 1'b1;
            on_nxt = '0; val_nxt = '0; rchord_nxt = '0;
          end
          default: begin
          end
        endcase
        off_mask_nxt = off_do_nxt ? sound_r : 12'd0;
        if (off_do_nxt) begin
          sound_nxt = 12'd0;
        end
      end
      ST_READ_B: begin
        state_nxt = ST_ON;
      end
      ST_ON: begin
        state_nxt = ST_EMIT;
        ld.load = 1'b1;
        ld.off_mask = off_mask_r;
        ld.off_base = off_base_r;
        ld.on_base = octave_base(e_root);
        ld.on_mask = '0;
        if (on_do_r && on_r[pos_r]) begin
          ld.on_mask = (e_chord == 12'd0) ? (12'd1 << pitch_class(e_root)) : e_chord;
          sound_nxt = ld.on_mask;
        end
      end
      ST_EMIT: begin
        if (!scan_busy) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
    wdata = {n_chord, n_root};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tempo_r <= TEMPO_RESET; chan_r <= '0;
      play_r <= 1'b0; ext_r <= 1'b0; pos_r <= '0; pulse_r <= '0; ms_r <= '0;
      rnote_r <= NOTE_DEFAULT; rvalid_r <= 1'b0; rchord_r <= '0;
      editv_r <= 1'b0; editp_r <= '0; sound_r <= '0;
      on_r <= '0; val_r <= '0; off_do_r <= 1'b0; on_do_r <= 1'b0;
    end else begin
      if (cfg_ch.valid && cfg_ch.index == CFG_TEMPO) begin
        tempo_r <= cfg_ch.data;
      end
      if (cfg_ch.valid && cfg_ch.index == CFG_CHANNEL) begin
        chan_r <= cfg_ch.data[3:0];
      end
      play_r <= play_nxt; ext_r <= ext_nxt; pos_r <= pos_nxt; pulse_r <= pulse_nxt;
      ms_r <= ms_nxt; rnote_r <= rnote_nxt; rvalid_r <= rvalid_nxt; rchord_r <= rchord_nxt;
      editv_r <= editv_nxt; editp_r <= editp_nxt; sound_r <= sound_nxt;
      on_r <= on_nxt; val_r <= val_nxt; off_do_r <= off_do_nxt; on_do_r <= on_do_nxt;
    end
    if (in_ch.valid && in_ch.ready) begin
      it_r <= in_ch.data;
    end
    off_mask_r <= off_mask_nxt;
    off_base_r <= off_base_nxt;
    prod_r <= 26'({1'b0, elapsed} + 17'd1) * 26'(bpm);
  end

  assign in_ch.ready  = (state_r == ST_IDLE);
  assign cfg_ch.ready = 1'b1;

  mcss_scan u_scan (
    .clk(clk), .rst_n(rst_n), .ld(ld), .channel(chan_r), .position(pos_ext[3:0]),
    .running(play_r), .busy(scan_busy), .out_ch(out_ch)
  );
endmodule

[hdl/mcss_ram.sv]
// ----------------------------------------------------------------------------
// mcss_ram
// generic single write, single read ram with registered read data
// ----------------------------------------------------------------------------
module mcss_ram #(
  parameter int WIDTH = 20,
  parameter int DEPTH = 16
) (
  input  logic                                 clk,
  input  logic                                 we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                     wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                     rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

[hdl/mcss_scan.sv]
// ----------------------------------------------------------------------------
// mcss_scan
// event scanner: a single pitch sum walks off then on bits, one per transfer
// ----------------------------------------------------------------------------
`include "midi_chord_step_sequencer_top_macros.svh"

module mcss_scan import mcss_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  scan_load_t          ld,
  input  logic [3:0]          channel,
  input  logic [3:0]          position,
  input  logic                running,
  output logic                busy,
  mcss_event_if.source        out_ch
);
  logic [23:0] vec_r, vec_nxt;
  logic [7:0]  off_base_r, on_base_r;
  logic [11:0] ok_off, ok_on;
  logic [4:0]  idx;
  logic [7:0]  sum;
  logic        fire;

  always_comb begin
    for (int i = 0; i < NOTES; i++) begin
      ok_off[i] = (9'(ld.off_base) + 9'(i)) <= 9'(PITCH_MAX);
      ok_on[i]  = (9'(ld.on_base) + 9'(i)) <= 9'(PITCH_MAX);
    end
  end

  always_comb begin
    idx = 5'd0;
    for (int i = 23; i >= 0; i--) begin
      if (vec_r[i]) begin
        idx = 5'(i);
      end
    end
  end

  assign sum = (idx < 5'd12) ? off_base_r + 8'(idx) : on_base_r + 8'(idx - 5'd12);
  assign fire = out_ch.valid && out_ch.ready;
  assign busy = |vec_r;

  always_comb begin
    vec_nxt = vec_r;
    if (ld.load) begin
      vec_nxt = {ld.on_mask & ok_on, ld.off_mask & ok_off};
    end else if (fire) begin
      vec_nxt = vec_r & (vec_r - 24'd1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vec_r <= '0;
    end else begin
      vec_r <= vec_nxt;
    end
    if (ld.load) begin
      off_base_r <= ld.off_base;
      on_base_r  <= ld.on_base;
    end
  end

  assign out_ch.valid         = busy;
  assign out_ch.data.note_on  = (idx >= 5'd12);
  assign out_ch.data.pitch    = sum[6:0];
  assign out_ch.data.velocity = (idx >= 5'd12) ? VEL_ON : 7'd0;
  assign out_ch.data.channel  = channel;
  assign out_ch.data.last     = ((vec_r & (vec_r - 24'd1)) == 24'd0);
  assign out_ch.data.position = position;
  assign out_ch.data.running  = running;

  `MCSS_ASSERT_SAME(a_load_idle, clk, rst_n, ld.load, vec_r == 24'd0, "load while scanning")
  `MCSS_ASSERT_NEXT(a_last_ends, clk, rst_n, fire && out_ch.data.last, !out_ch.valid, "events after last")
  `MCSS_ASSERT_SAME(a_pitch_range, clk, rst_n, out_ch.valid, sum <= PITCH_MAX, "pitch above range")
endmodule

[tb/midi_chord_step_sequencer_top_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// midi_chord_step_sequencer_top_tb
// Drives edit, transport and clock items into the chord sequencer and runs
// its own model of the step store, the transport and the note scan. Every
// note event is checked field by field against the model, under random
// stalls on both sides and several tempo and channel settings.
// ----------------------------------------------------------------------------
module midi_chord_step_sequencer_top_tb;
  import mcss_pkg::*;

  localparam int STEPS      = 16;
  localparam int PULSES     = 6;
  localparam int MAX_EVENTS = 24;
  localparam int SETTLE     = 40;

  logic clk;
  logic rst_n;
  bit   steady;
  int   errors;

  mcss_item_if  in_ch ();
  mcss_event_if out_ch ();
  mcss_cfg_if   cfg_ch ();

  midi_chord_step_sequencer_top #(.NUM_STEPS(STEPS), .PULSES_STEP(PULSES)) dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  // sequencer model state
  logic [8:0]  m_tempo;
  logic [3:0]  m_chan;
  bit          m_play;
  bit          m_ext;
  logic [3:0]  m_pos;
  int          m_pulse;
  int          m_ms;
  int          m_note;
  bit          m_note_ok;
  logic [11:0] m_mem_chord;
  bit          m_edit_ok;
  logic [3:0]  m_edit_pos;
  logic [11:0] m_sound;
  bit          m_on [STEPS];
  logic [11:0] m_chord [STEPS];
  int          m_root [STEPS];

  out_event_t  note_batch[$];
  out_event_t  pending_notes[$];

  function automatic int octave_floor(int n);
    return n - (n % 12);
  endfunction

  function automatic void add_note(bit on, int p);
    out_event_t e;
    if (p > 127 || note_batch.size() >= MAX_EVENTS) return;
    e = '0;
    e.note_on  = on;
    e.pitch    = p[6:0];
    e.velocity = on ? VEL_ON : 7'd0;
    e.channel  = m_chan;
    note_batch.push_back(e);
  endfunction

  function automatic void notes_off_model();
    int b;
    b = octave_floor(m_root[m_pos]);
    for (int i = 0; i < NOTES; i++)
      if (m_sound[i]) add_note(1'b0, b + i);
    m_sound = '0;
  endfunction

  function automatic void notes_on_model();
    int b;
    b = octave_floor(m_root[m_pos]);
    if (!m_on[m_pos]) return;
    if (m_chord[m_pos] == 0) begin
      add_note(1'b1, m_root[m_pos]);
      m_sound = 12'(1) << (m_root[m_pos] % 12);
      return;
    end
    m_sound = m_chord[m_pos];
    for (int i = 0; i < NOTES; i++)
      if (m_chord[m_pos][i]) add_note(1'b1, b + i);
  endfunction

  function automatic void advance_model();
    notes_off_model();
    m_pos = m_pos + 4'd1;
    notes_on_model();
    m_ms = 0;
  endfunction

  function automatic void start_model();
    notes_off_model();
    m_play  = 1;
    m_pos   = '0;
    m_pulse = 0;
    m_ms    = 0;
    notes_on_model();
  endfunction

  function automatic int root_of_chord(logic [11:0] c);
    int src;
    src = m_note_ok ? m_note : 60;
    for (int i = 0; i < NOTES; i++)
      if (c[i]) return octave_floor(src) + i;
    return src;
  endfunction

  function automatic void clear_model();
    for (int i = 0; i < STEPS; i++) begin
      m_on[i]    = 0;
      m_chord[i] = '0;
      m_root[i]  = 60;
    end
  endfunction

  function automatic void reset_model();
    m_tempo = TEMPO_RESET; m_chan = '0;
    m_play = 0; m_ext = 0; m_pos = '0; m_pulse = 0; m_ms = 0;
    m_note = 60; m_note_ok = 0; m_mem_chord = '0;
    m_edit_ok = 0; m_edit_pos = '0; m_sound = '0;
    clear_model();
  endfunction

  function automatic void toggle_step_model(logic [3:0] s, logic [11:0] offered);
    bit here;
    int src;
    here = m_play && m_pos == s;
    if (!m_on[s]) begin
      m_on[s] = 1;
      if (m_chord[s] != 0) begin
      end else if (offered != 0) begin
        m_chord[s] = offered;
        m_mem_chord = offered;
        m_root[s] = root_of_chord(offered);
      end else if (m_mem_chord != 0) begin
        m_chord[s] = m_mem_chord;
        m_root[s] = root_of_chord(m_mem_chord);
      end else begin
        src = m_note_ok ? m_note : 60;
        m_root[s] = src;
        m_chord[s] = 12'(1) << (src % 12);
      end
      if (here) begin
        notes_off_model();
        notes_on_model();
      end
    end else begin
      if (here) notes_off_model();
      m_on[s] = 0;
    end
  endfunction

  function automatic void toggle_key_model(logic [3:0] k);
    logic [3:0] s;
    s = m_edit_pos;
    if (!m_edit_ok || k >= NOTES || !m_on[s]) return;
    m_chord[s][k] = ~m_chord[s][k];
    if (m_chord[s][k]) m_root[s] = octave_floor(m_root[s]) + k;
    if (m_chord[s] == 0) m_on[s] = 0;
    else m_mem_chord = m_chord[s];
  endfunction

  function automatic void tick_model();
    int bpm, interval, elapsed;
    bpm = (m_tempo != 0) ? int'(m_tempo) : 1;
    interval = 60000 / (bpm * 4);
    elapsed = (m_ms < 65535) ? m_ms + 1 : 65535;
    if (!m_ext && m_play && elapsed >= interval) advance_model();
    else m_ms = elapsed;
  endfunction

  function automatic void predict_notes(in_item_t it);
    note_batch.delete();
    case (it.action)
      ACT_MIDI_BYTE: begin
        case (it.clock_byte)
          MB_PULSE: begin
            m_pulse++;
            if (m_pulse >= PULSES) begin
              m_pulse = 0;
              if (m_play) advance_model();
            end
          end
          MB_START: begin
            m_ext = 1;
            start_model();
          end
          MB_CONT: begin
            m_ext = 1;
            m_play = 1;
          end
          MB_STOP: begin
            m_ext = 0;
            m_play = 0;
            m_pulse = 0;
            notes_off_model();
          end
          default: ;
        endcase
      end
      ACT_MS_TICK: tick_model();
      ACT_TOGGLE_PLAY: begin
        if (m_play) begin
          m_play = 0;
          notes_off_model();
        end else begin
          start_model();
        end
      end
      ACT_TOGGLE_STEP: toggle_step_model(it.step_index, it.chord_mask);
      ACT_BEGIN_EDIT: begin
        m_edit_ok = 1;
        m_edit_pos = it.step_index;
      end
      ACT_END_EDIT: m_edit_ok = 0;
      ACT_TOGGLE_KEY: toggle_key_model(it.key_index);
      ACT_SET_NOTE: begin
        m_note = it.note_value;
        m_note_ok = 1;
      end
      ACT_CLEAR: begin
        notes_off_model();
        clear_model();
        m_mem_chord = '0;
      end
      default: ;
    endcase
    foreach (note_batch[k]) begin
      note_batch[k].last     = (k == note_batch.size() - 1);
      note_batch[k].position = m_pos;
      note_batch[k].running  = m_play;
      pending_notes.push_back(note_batch[k]);
    end
  endfunction

  task automatic report_mismatch(string msg);
    errors++;
    if (errors <= 60) $display("ERROR %0t: %s", $time, msg);
  endtask

  task automatic check_note(out_event_t got);
    out_event_t exp;
    if (pending_notes.size() == 0) begin
      report_mismatch($sformatf("unexpected event %p", got));
      return;
    end
    exp = pending_notes.pop_front();
    if (got.note_on !== exp.note_on)
      report_mismatch($sformatf("note_on %0b exp %0b", got.note_on, exp.note_on));
    if (got.pitch !== exp.pitch)
      report_mismatch($sformatf("pitch %0d exp %0d", got.pitch, exp.pitch));
    if (got.velocity !== exp.velocity)
      report_mismatch($sformatf("velocity %0d exp %0d", got.velocity, exp.velocity));
    if (got.channel !== exp.channel)
      report_mismatch($sformatf("channel %0d exp %0d", got.channel, exp.channel));
    if (got.last !== exp.last)
      report_mismatch($sformatf("last %0b exp %0b", got.last, exp.last));
    if (got.position !== exp.position)
      report_mismatch($sformatf("position %0d exp %0d", got.position, exp.position));
    if (got.running !== exp.running)
      report_mismatch($sformatf("running %0b exp %0b", got.running, exp.running));
  endtask

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // event sink with random stalls
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) check_note(out_ch.data);
    out_ch.ready <= rst_n && (steady || $urandom_range(99) >= 27);
  end

  task automatic send_item(in_item_t it);
    int gap;
    if (!steady && $urandom_range(99) < 27) begin
      gap = $urandom_range(1, 6);
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data  <= it;
    do @(posedge clk); while (!in_ch.ready);
    predict_notes(it);
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (pending_notes.size() != 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    if (idx == CFG_TEMPO) m_tempo = val;
    else if (idx == CFG_CHANNEL) m_chan = val[3:0];
    @(posedge clk);
  endtask

  function automatic in_item_t make_item(logic [3:0] act);
    in_item_t it;
    it = '0;
    it.action = act;
    return it;
  endfunction

  task automatic send_action(logic [3:0] act);
    send_item(make_item(act));
  endtask

  task automatic send_byte(logic [7:0] b);
    in_item_t it;
    it = make_item(ACT_MIDI_BYTE);
    it.clock_byte = b;
    send_item(it);
  endtask

  task automatic send_step(logic [3:0] s, logic [11:0] mask);
    in_item_t it;
    it = make_item(ACT_TOGGLE_STEP);
    it.step_index = s;
    it.chord_mask = mask;
    send_item(it);
  endtask

  task automatic send_key(logic [3:0] k);
    in_item_t it;
    it = make_item(ACT_TOGGLE_KEY);
    it.key_index = k;
    send_item(it);
  endtask

  task automatic send_note(logic [6:0] n);
    in_item_t it;
    it = make_item(ACT_SET_NOTE);
    it.note_value = n;
    send_item(it);
  endtask

  // pattern editing: offered, remembered and default chords, key toggles
  task automatic test_edit_pattern();
    in_item_t it;
    send_step(4'd1, 12'h000);
    send_note(7'd127);
    send_step(4'd0, 12'hFFF);
    send_step(4'd2, 12'h000);
    it = make_item(ACT_BEGIN_EDIT);
    it.step_index = 4'd15;
    send_item(it);
    send_key(4'd12);
    send_key(4'd15);
    send_step(4'd15, 12'h091);
    send_key(4'd0);
    send_key(4'd11);
    send_key(4'd4);
    send_action(ACT_END_EDIT);
    send_key(4'd7);
    send_note(7'd0);
    send_step(4'd3, 12'h800);
    drain();
  endtask

  // transport: play toggle, start/continue/stop, clock pulses, unknown codes
  task automatic test_transport();
    send_action(ACT_TOGGLE_PLAY);
    send_step(4'd0, 12'h001);
    send_step(4'd0, 12'h000);
    send_byte(MB_START);
    repeat (13) send_byte(MB_PULSE);
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(MB_STOP);
    send_byte(MB_CONT);
    repeat (7) send_byte(MB_PULSE);
    send_action(4'd9);
    send_action(4'd15);
    send_action(ACT_TOGGLE_PLAY);
    send_action(ACT_TOGGLE_PLAY);
    send_action(ACT_CLEAR);
    send_action(ACT_TOGGLE_PLAY);
    drain();
  endtask

  // internal millisecond timer at fast and zero tempo
  task automatic test_internal_tempo();
    write_reg(CFG_TEMPO, 9'd511);
    write_reg(CFG_CHANNEL, 4'd15);
    send_step(4'd1, 12'h0A5);
    send_step(4'd2, 12'h000);
    send_action(ACT_TOGGLE_PLAY);
    repeat (70) send_action(ACT_MS_TICK);
    send_byte(MB_STOP);
    drain();
    write_reg(CFG_TEMPO, 9'd0);
    write_reg(CFG_CHANNEL, 4'd0);
    send_action(ACT_TOGGLE_PLAY);
    repeat (5) send_action(ACT_MS_TICK);
    send_action(ACT_TOGGLE_PLAY);
    drain();
  endtask

  function automatic in_item_t random_item();
    in_item_t it;
    int r;
    it.action     = 4'($urandom);
    it.clock_byte = 8'($urandom);
    it.step_index = 4'($urandom);
    it.chord_mask = 12'($urandom);
    it.key_index  = 4'($urandom);
    it.note_value = 7'($urandom);
    r = $urandom_range(99);
    if (r < 20) begin
      it.action = ACT_MIDI_BYTE;
      case ($urandom_range(9))
        0: it.clock_byte = MB_START;
        1: it.clock_byte = MB_CONT;
        2: it.clock_byte = MB_STOP;
        3: ;
        default: it.clock_byte = MB_PULSE;
      endcase
    end else if (r < 42) it.action = ACT_MS_TICK;
    else if (r < 49) it.action = ACT_TOGGLE_PLAY;
    else if (r < 64) begin
      it.action = ACT_TOGGLE_STEP;
      if ($urandom_range(3) == 0) it.chord_mask = '0;
    end else if (r < 70) it.action = ACT_BEGIN_EDIT;
    else if (r < 73) it.action = ACT_END_EDIT;
    else if (r < 85) begin
      it.action = ACT_TOGGLE_KEY;
      if ($urandom_range(4) != 0) it.key_index = 4'($urandom_range(11));
    end else if (r < 92) it.action = ACT_SET_NOTE;
    else if (r < 94) it.action = ACT_CLEAR;
    return it;
  endfunction

  task automatic test_random_phase(logic [8:0] tempo, logic [3:0] chan, int count);
    write_reg(CFG_TEMPO, tempo);
    write_reg(CFG_CHANNEL, chan);
    repeat (count) send_item(random_item());
    drain();
  endtask

  initial begin
    errors = 0;
    steady = 0;
    reset_model();
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = '0;
    cfg_ch.data = '0;
    out_ch.ready = 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    repeat (4) @(posedge clk);
    test_edit_pattern();
    test_transport();
    test_internal_tempo();
    test_random_phase(9'd300, 4'd9, 35);
    test_random_phase(9'd1, 4'd0, 20);
    steady = 1;
    test_random_phase(9'd511, 4'd15, 50);
    steady = 0;
    test_random_phase(9'd120, 4'd5, 35);
    if (errors == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

  initial begin
    #5_000_000;
    $display("FAILURE");
    $finish;
  end

endmodule
